// ===== rtl/software_timer_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Software timer table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Software timer table package
// Word types, slot record, operation and result codes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  // Default table depth
  localparam int unsigned N_SLOTS_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_APP_TASK_ID = 1'b0;

  // Field widths
  localparam int unsigned ACT_W = 5;

  // Operation codes
  localparam logic [2:0] OP_START_ONESHOT = 3'd0;
  localparam logic [2:0] OP_START_RELOAD  = 3'd1;
  localparam logic [2:0] OP_STOP          = 3'd2;
  localparam logic [2:0] OP_QUERY         = 3'd3;
  localparam logic [2:0] OP_TICK          = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;
  localparam logic [1:0] KIND_IDLE   = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] task_id;
    logic [15:0] evt_bits;
    logic [31:0] timeout_ms;
    logic [31:0] elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [15:0]      fired_task;
    logic [15:0]      fired_event;
    logic             as_message;
    logic [31:0]      remaining_ms;
    logic [ACT_W-1:0] active_count;
    logic [31:0]      clock_ms;
    logic             last;
  } out_word_t;

  // One timer slot as held in the slot RAM
  typedef struct packed {
    logic [15:0] task_id;
    logic [15:0] evt_bits;
    logic [31:0] remaining;
    logic [31:0] period;
  } slot_entry_t;

  // Slot unit verdict for the slot under test
  typedef struct packed {
    logic        match;
    logic        fire;
    logic        as_msg;
    logic        keep;
    logic [31:0] remaining;
  } slot_res_t;

endpackage

`default_nettype wire

// ===== rtl/stt_slot_unit.sv =====
// ----------------------------------------------------------------------------
// Software timer slot unit
// Shared compare-subtract for one slot: key match, saturating count-down,
// reload and one-shot expiry decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_slot_unit import stt_pkg::*; (
  input  slot_entry_t ent_i,
  input  logic [31:0] elapsed_i,
  input  logic [15:0] key_task_i,
  input  logic [15:0] key_event_i,
  input  logic [15:0] app_task_i,
  output slot_res_t   res_o
);

  logic [32:0] diff;
  logic [31:0] dec;
  logic        reload_fire;
  logic [31:0] rem_after;
  logic        drop;
  logic        oneshot_fire;

  // Saturating subtract: borrow means the timer ran out
  assign diff = {1'b0, ent_i.remaining} - {1'b0, elapsed_i};
  assign dec  = diff[32] ? '0 : diff[31:0];

  // Reload timer hits zero and rearms with its period
  assign reload_fire = (dec == '0) && (ent_i.period != '0) && (ent_i.evt_bits != '0);
  assign rem_after   = reload_fire ? ent_i.period : dec;

  // One-shot expiry or stopped timer frees the slot
  assign drop         = (rem_after == '0) || (ent_i.evt_bits == '0);
  assign oneshot_fire = (rem_after == '0) && (ent_i.evt_bits != '0);

  assign res_o.match     = (ent_i.task_id == key_task_i) && (ent_i.evt_bits == key_event_i);
  assign res_o.fire      = reload_fire || oneshot_fire;
  assign res_o.as_msg    = oneshot_fire && (ent_i.task_id == app_task_i);
  assign res_o.keep      = !drop;
  assign res_o.remaining = rem_after;

endmodule

`default_nettype wire

// ===== rtl/software_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// Software timer table core
// A table of N_SLOTS timers keyed by task and event bits, held in a slot
// RAM and walked one slot per cycle by a small sequencer around a single
// compare-subtract unit. Every item scans the whole table: a start, stop,
// query, unused op code or tick without expiry then passes a finish state
// and a response state, where its one word is loaded into the output
// register once that register is empty or being read, and in_ready
// returns. A tick with expiries passes the same finish state, then walks
// the slots again up to the last one that fired to report expiries in slot
// order: slots that did not fire are passed over, and each expiry takes a
// RAM read, then an output load, which waits while the consumer stalls.
// The pace is set by the single RAM read port and the one unit shared by
// all slots. All result words of a tick carry the count and clock after the
// tick. No clearing pass: slot valid bits reset in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_table_core import stt_pkg::*; #(
  parameter int unsigned N_SLOTS = N_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(N_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_FINISH  = 6'b000100,
    S_RESP    = 6'b001000,
    S_EMIT    = 6'b010000,
    S_EMIT_LD = 6'b100000
  } state_t;

  // Control state
  state_t                state_r, state_nxt;
  logic [15:0]           app_task_r, app_task_nxt;
  logic [31:0]           clock_r, clock_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [N_SLOTS-1:0]    valid_r, valid_nxt;
  logic [N_SLOTS-1:0]    fire_r, fire_nxt;
  logic [N_SLOTS-1:0]    msg_r, msg_nxt;
  logic [CNT_W-1:0]      fire_cnt_r, fire_cnt_nxt;
  logic [CNT_W-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  issue_done_r, issue_done_nxt;
  logic                  ex_vld_r, ex_vld_nxt;
  logic [IDX_W-1:0]      ex_idx_r, ex_idx_nxt;
  logic [IDX_W-1:0]      emit_idx_r, emit_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      found_idx_r, found_idx_nxt;
  logic                  free_r, free_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload state
  in_word_t              item_r, item_nxt;
  slot_entry_t           found_ent_r, found_ent_nxt;
  logic [1:0]            resp_kind_r, resp_kind_nxt;
  logic [1:0]            resp_status_r, resp_status_nxt;
  logic [31:0]           resp_rem_r, resp_rem_nxt;
  out_word_t             out_data_r, out_data_nxt;

  // Slot RAM
  slot_entry_t           slot_mem [N_SLOTS];
  slot_entry_t           slot_rdata_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  slot_entry_t           mem_wdata;

  slot_res_t             unit_res;
  logic                  accept;
  logic                  out_free;
  logic                  is_tick;
  logic                  is_reload;
  logic                  emit_last;
  logic                  cfg_wr;

  // Shared slot unit
  stt_slot_unit u_slot_unit (
    .ent_i       (slot_rdata_r),
    .elapsed_i   (item_r.elapsed_ms),
    .key_task_i  (item_r.task_id),
    .key_event_i (item_r.evt_bits),
    .app_task_i  (app_task_r),
    .res_o       (unit_res)
  );

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign is_tick   = (item_r.op == OP_TICK);
  assign is_reload = (item_r.op == OP_START_RELOAD);
  assign emit_last = (CNT_W'(emit_cnt_r + 1'b1) == fire_cnt_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[CFG_ADDR_W-1:2] == REG_APP_TASK_ID);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_APP_TASK_ID) ?
                  {{(CFG_DATA_W-16){1'b0}}, app_task_r} : '0;
  assign app_task_nxt = cfg_wr ? pwdata[15:0] : app_task_r;

  // RAM read address: scan pointer, or expiry walk pointer
  assign rd_addr = ((state_r == S_EMIT) || (state_r == S_EMIT_LD)) ? emit_idx_r : rd_idx_r;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    clock_nxt       = clock_r;
    cnt_nxt         = cnt_r;
    valid_nxt       = valid_r;
    fire_nxt        = fire_r;
    msg_nxt         = msg_r;
    fire_cnt_nxt    = fire_cnt_r;
    emit_cnt_nxt    = emit_cnt_r;
    rd_idx_nxt      = rd_idx_r;
    issue_done_nxt  = issue_done_r;
    ex_vld_nxt      = ex_vld_r;
    ex_idx_nxt      = ex_idx_r;
    emit_idx_nxt    = emit_idx_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    item_nxt        = item_r;
    found_ent_nxt   = found_ent_r;
    resp_kind_nxt   = resp_kind_r;
    resp_status_nxt = resp_status_r;
    resp_rem_nxt    = resp_rem_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r;
    mem_we          = 1'b0;
    mem_waddr       = ex_idx_r;
    mem_wdata       = slot_rdata_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt       = in_data;
          rd_idx_nxt     = '0;
          issue_done_nxt = 1'b0;
          ex_vld_nxt     = 1'b0;
          found_nxt      = 1'b0;
          free_nxt       = 1'b0;
          fire_cnt_nxt   = '0;
          emit_cnt_nxt   = '0;
          emit_idx_nxt   = '0;
          fire_nxt       = '0;
          msg_nxt        = '0;
          if (in_data.op == OP_TICK) begin
            clock_nxt = clock_r + in_data.elapsed_ms;
          end
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // read issue, one slot a cycle
        ex_vld_nxt = !issue_done_r;
        ex_idx_nxt = rd_idx_r;
        if (!issue_done_r) begin
          if (rd_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        // slot under test
        if (ex_vld_r) begin
          if (is_tick) begin
            if (valid_r[ex_idx_r]) begin
              mem_we               = 1'b1;
              mem_wdata.remaining  = unit_res.remaining;
              fire_nxt[ex_idx_r]   = unit_res.fire;
              msg_nxt[ex_idx_r]    = unit_res.as_msg;
              if (unit_res.fire) begin
                fire_cnt_nxt = fire_cnt_r + 1'b1;
              end
              if (!unit_res.keep) begin
                valid_nxt[ex_idx_r] = 1'b0;
                cnt_nxt             = cnt_r - 1'b1;
              end
            end
          end else begin
            if (valid_r[ex_idx_r] && unit_res.match && !found_r) begin
              found_nxt     = 1'b1;
              found_idx_nxt = ex_idx_r;
              found_ent_nxt = slot_rdata_r;
            end
            if (!valid_r[ex_idx_r] && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = ex_idx_r;
            end
          end
          if (ex_idx_r == LAST_IDX) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        resp_kind_nxt   = KIND_STATUS;
        resp_status_nxt = STATUS_OK;
        resp_rem_nxt    = '0;
        state_nxt       = S_RESP;
        case (item_r.op)
          OP_START_ONESHOT, OP_START_RELOAD: begin
            if (found_r) begin
              mem_we              = 1'b1;
              mem_waddr           = found_idx_r;
              mem_wdata           = found_ent_r;
              mem_wdata.remaining = item_r.timeout_ms;
              if (is_reload) begin
                mem_wdata.period = item_r.timeout_ms;
              end
            end else if (free_r) begin
              mem_we               = 1'b1;
              mem_waddr            = free_idx_r;
              mem_wdata.task_id    = item_r.task_id;
              mem_wdata.evt_bits   = item_r.evt_bits;
              mem_wdata.remaining  = item_r.timeout_ms;
              mem_wdata.period     = is_reload ? item_r.timeout_ms : '0;
              valid_nxt[free_idx_r] = 1'b1;
              cnt_nxt               = cnt_r + 1'b1;
            end else begin
              resp_status_nxt = STATUS_NO_SLOT;
            end
          end
          OP_STOP: begin
            if (found_r) begin
              mem_we             = 1'b1;
              mem_waddr          = found_idx_r;
              mem_wdata          = found_ent_r;
              mem_wdata.evt_bits = '0;
            end else begin
              resp_status_nxt = STATUS_NOT_FOUND;
            end
          end
          OP_QUERY: begin
            resp_kind_nxt = KIND_QUERY;
            if (found_r) begin
              resp_rem_nxt = found_ent_r.remaining;
            end else begin
              resp_status_nxt = STATUS_NOT_FOUND;
            end
          end
          OP_TICK: begin
            if (fire_cnt_r == '0) begin
              resp_kind_nxt = KIND_IDLE;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: begin
            resp_kind_nxt = KIND_STATUS;
          end
        endcase
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.kind         = resp_kind_r;
          out_data_nxt.status       = resp_status_r;
          out_data_nxt.remaining_ms = resp_rem_r;
          out_data_nxt.active_count = ACT_W'(cnt_r);
          out_data_nxt.clock_ms     = clock_r;
          out_data_nxt.last         = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      S_EMIT: begin
        // skip slots that did not fire
        if (fire_r[emit_idx_r]) begin
          state_nxt = S_EMIT_LD;
        end else begin
          emit_idx_nxt = emit_idx_r + 1'b1;
        end
      end

      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.kind         = KIND_EXPIRY;
          out_data_nxt.status       = STATUS_OK;
          out_data_nxt.fired_task   = slot_rdata_r.task_id;
          out_data_nxt.fired_event  = slot_rdata_r.evt_bits;
          out_data_nxt.as_message   = msg_r[emit_idx_r];
          out_data_nxt.active_count = ACT_W'(cnt_r);
          out_data_nxt.clock_ms     = clock_r;
          out_data_nxt.last         = emit_last;
          emit_cnt_nxt              = emit_cnt_r + 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
            state_nxt    = S_EMIT;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      app_task_r   <= '0;
      clock_r      <= '0;
      cnt_r        <= '0;
      valid_r      <= '0;
      fire_r       <= '0;
      msg_r        <= '0;
      fire_cnt_r   <= '0;
      emit_cnt_r   <= '0;
      rd_idx_r     <= '0;
      issue_done_r <= 1'b0;
      ex_vld_r     <= 1'b0;
      ex_idx_r     <= '0;
      emit_idx_r   <= '0;
      found_r      <= 1'b0;
      found_idx_r  <= '0;
      free_r       <= 1'b0;
      free_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      app_task_r   <= app_task_nxt;
      clock_r      <= clock_nxt;
      cnt_r        <= cnt_nxt;
      valid_r      <= valid_nxt;
      fire_r       <= fire_nxt;
      msg_r        <= msg_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      rd_idx_r     <= rd_idx_nxt;
      issue_done_r <= issue_done_nxt;
      ex_vld_r     <= ex_vld_nxt;
      ex_idx_r     <= ex_idx_nxt;
      emit_idx_r   <= emit_idx_nxt;
      found_r      <= found_nxt;
      found_idx_r  <= found_idx_nxt;
      free_r       <= free_nxt;
      free_idx_r   <= free_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    found_ent_r   <= found_ent_nxt;
    resp_kind_r   <= resp_kind_nxt;
    resp_status_r <= resp_status_nxt;
    resp_rem_r    <= resp_rem_nxt;
    out_data_r    <= out_data_nxt;
  end

  // Slot RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    slot_rdata_r <= slot_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/stt_port_checker.sv =====
// ----------------------------------------------------------------------------
// Software timer table port checker
// Watches the word channels of the core and flags ordering and content slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "software_timer_table_core_defines.svh"

module stt_port_checker import stt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // one item at a time: busy right after an accepted word
  `STT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // stalled result word holds
  `STT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out word changed while stalled")

  // only expiry words can be followed by more words of the same item
  `STT_ASSERT_NOW(a_single_last, out_valid && (out_data.kind != KIND_EXPIRY), out_data.last, "single word not marked last")

  // expiry words carry a real event and no query fields
  `STT_ASSERT_NOW(a_expiry_shape, out_valid && (out_data.kind == KIND_EXPIRY), (out_data.status == STATUS_OK) && (out_data.remaining_ms == '0) && (out_data.fired_event != '0), "malformed expiry word")

endmodule

bind software_timer_table_core stt_port_checker u_stt_port_checker (.*);

`default_nettype wire

// ===== bench/tb_software_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// Software timer table core testbench
// Sends start, stop, query, tick and unused command words into the timer
// table, predicts result words with a behavioral timer table or takes them
// from directed rows, and checks each result field by field. A directed table
// opens the run, then random phases run under several app task settings with
// bursty input traffic, result back-pressure and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_software_timer_table_core;
  import stt_pkg::*;

  localparam int unsigned NT          = N_SLOTS_DEF;
  localparam int unsigned N_DIRECTED  = 24;
  localparam int unsigned N_PHASES    = 4;
  localparam int unsigned PHASE_ITEMS = 72;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 2 * NT + 8;
  localparam int unsigned RUN_LIMIT   = 5_000_000;

  // random traffic mixes
  localparam int unsigned MIX_MIXED = 0;
  localparam int unsigned MIX_FILL  = 1;
  localparam int unsigned MIX_TICKS = 2;

  localparam logic [CFG_ADDR_W-1:0] APP_TASK_ADDR = CFG_ADDR_W'(4 * REG_APP_TASK_ID);

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  software_timer_table_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Timer table shadow
  bit          tmr_valid  [NT];
  logic [15:0] tmr_task   [NT];
  logic [15:0] tmr_event  [NT];
  logic [31:0] tmr_left   [NT];
  logic [31:0] tmr_period [NT];
  logic [31:0] sys_clock_ms;
  logic [15:0] app_task;

  out_word_t   expected_words [$];
  stim_row_t   directed_rows [N_DIRECTED];
  logic [15:0] task_pool [4];
  logic [15:0] event_pool [4];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned expiries_seen;
  int unsigned full_answers;
  int unsigned burst_left;
  bit          hold_off_req;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin : watchdog
    #RUN_LIMIT;
    $display("FAIL");
    $finish;
  end

  // Lowest valid slot holding this key, -1 when absent
  function automatic int find_timer(input logic [15:0] tsk, input logic [15:0] ev);
    int i;
    find_timer = -1;
    for (i = NT - 1; i >= 0; i--)
      if (tmr_valid[i] && tmr_task[i] == tsk && tmr_event[i] == ev) find_timer = i;
  endfunction

  // Apply one accepted word to the shadow; queue its results when asked
  task automatic advance_table(input in_word_t w, input bit record);
    out_word_t batch [NT + 1];
    int        cnt;
    int        hit;
    int        i;
    int        act;
    cnt = 0;
    for (i = 0; i <= NT; i++) batch[i] = '0;
    case (w.op)
      OP_START_ONESHOT, OP_START_RELOAD: begin
        batch[0].kind   = KIND_STATUS;
        batch[0].status = STATUS_OK;
        hit = find_timer(w.task_id, w.evt_bits);
        if (hit < 0) begin
          for (i = NT - 1; i >= 0; i--)
            if (!tmr_valid[i]) hit = i;
          if (hit >= 0) begin
            tmr_valid[hit]  = 1'b1;
            tmr_task[hit]   = w.task_id;
            tmr_event[hit]  = w.evt_bits;
            tmr_period[hit] = '0;
          end
        end
        if (hit < 0) begin
          batch[0].status = STATUS_NO_SLOT;
          full_answers++;
        end else begin
          tmr_left[hit] = w.timeout_ms;
          if (w.op == OP_START_RELOAD) tmr_period[hit] = w.timeout_ms;
        end
        cnt = 1;
      end
      OP_STOP: begin
        hit = find_timer(w.task_id, w.evt_bits);
        if (hit >= 0) tmr_event[hit] = '0;
        batch[0].kind   = KIND_STATUS;
        batch[0].status = (hit >= 0) ? STATUS_OK : STATUS_NOT_FOUND;
        cnt = 1;
      end
      OP_QUERY: begin
        hit = find_timer(w.task_id, w.evt_bits);
        batch[0].kind         = KIND_QUERY;
        batch[0].status       = (hit >= 0) ? STATUS_OK : STATUS_NOT_FOUND;
        batch[0].remaining_ms = (hit >= 0) ? tmr_left[hit] : '0;
        cnt = 1;
      end
      OP_TICK: begin
        sys_clock_ms = sys_clock_ms + w.elapsed_ms;
        for (i = 0; i < NT; i++) begin
          if (tmr_valid[i]) begin
            tmr_left[i] = (tmr_left[i] > w.elapsed_ms) ? tmr_left[i] - w.elapsed_ms : '0;
            // reload timer: report and rearm
            if (tmr_left[i] == 0 && tmr_period[i] != 0 && tmr_event[i] != 0) begin
              batch[cnt].kind        = KIND_EXPIRY;
              batch[cnt].fired_task  = tmr_task[i];
              batch[cnt].fired_event = tmr_event[i];
              cnt++;
              tmr_left[i] = tmr_period[i];
            end
            // one-shot expiry or stopped slot: free it
            if (tmr_left[i] == 0 || tmr_event[i] == 0) begin
              if (tmr_left[i] == 0 && tmr_event[i] != 0) begin
                batch[cnt].kind        = KIND_EXPIRY;
                batch[cnt].fired_task  = tmr_task[i];
                batch[cnt].fired_event = tmr_event[i];
                batch[cnt].as_message  = (tmr_task[i] == app_task);
                cnt++;
              end
              tmr_valid[i] = 1'b0;
            end
          end
        end
        if (cnt == 0) begin
          batch[0].kind = KIND_IDLE;
          cnt = 1;
        end
      end
      default: begin
        batch[0].kind   = KIND_STATUS;
        batch[0].status = STATUS_OK;
        cnt = 1;
      end
    endcase
    act = 0;
    for (i = 0; i < NT; i++) if (tmr_valid[i]) act++;
    for (i = 0; i < cnt; i++) begin
      batch[i].active_count = ACT_W'(act);
      batch[i].clock_ms     = sys_clock_ms;
      batch[i].last         = (i == cnt - 1);
      if (record) expected_words.push_back(batch[i]);
    end
  endtask

  // Directed row builders
  function automatic stim_row_t plain_row(input logic [2:0] op, input logic [15:0] tsk,
                                          input logic [15:0] ev, input logic [31:0] tmo,
                                          input logic [31:0] el);
    plain_row.w     = '{op: op, task_id: tsk, evt_bits: ev, timeout_ms: tmo, elapsed_ms: el};
    plain_row.typed = 1'b0;
    plain_row.want  = '0;
  endfunction

  function automatic stim_row_t typed_row(input logic [2:0] op, input logic [15:0] tsk,
                                          input logic [15:0] ev, input logic [31:0] tmo,
                                          input logic [31:0] el, input logic [1:0] kind,
                                          input logic [1:0] status, input logic [31:0] rem,
                                          input int act, input logic [31:0] clk_ms);
    typed_row              = plain_row(op, tsk, ev, tmo, el);
    typed_row.typed        = 1'b1;
    typed_row.want.kind         = kind;
    typed_row.want.status       = status;
    typed_row.want.remaining_ms = rem;
    typed_row.want.active_count = ACT_W'(act);
    typed_row.want.clock_ms     = clk_ms;
    typed_row.want.last         = 1'b1;
  endfunction

  // Directed table: runs right after reset with app task at its reset value 0
  task automatic load_directed();
    directed_rows[0]  = typed_row(OP_QUERY, 16'h0001, 16'h0001, 0, 0,
                                  KIND_QUERY, STATUS_NOT_FOUND, 0, 0, 0);
    directed_rows[1]  = typed_row(OP_STOP, 16'h0001, 16'h0001, 0, 0,
                                  KIND_STATUS, STATUS_NOT_FOUND, 0, 0, 0);
    directed_rows[2]  = typed_row(OP_TICK, 0, 0, 0, 0, KIND_IDLE, STATUS_OK, 0, 0, 0);
    directed_rows[3]  = typed_row(OP_START_ONESHOT, 16'h0000, 16'hFFFF, 0, 0,
                                  KIND_STATUS, STATUS_OK, 0, 1, 0);
    directed_rows[4]  = typed_row(OP_START_RELOAD, 16'hFFFF, 16'h0001, 32'hFFFF_FFFF, 0,
                                  KIND_STATUS, STATUS_OK, 0, 2, 0);
    directed_rows[5]  = typed_row(OP_START_ONESHOT, 16'h1234, 16'h8000, 5, 0,
                                  KIND_STATUS, STATUS_OK, 0, 3, 0);
    directed_rows[6]  = typed_row(OP_QUERY, 16'hFFFF, 16'h0001, 0, 0,
                                  KIND_QUERY, STATUS_OK, 32'hFFFF_FFFF, 3, 0);
    // unused op codes with every payload bit set
    directed_rows[7]  = typed_row(3'd5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  KIND_STATUS, STATUS_OK, 0, 3, 0);
    directed_rows[8]  = typed_row(3'd6, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  KIND_STATUS, STATUS_OK, 0, 3, 0);
    directed_rows[9]  = typed_row(3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  KIND_STATUS, STATUS_OK, 0, 3, 0);
    // zero timeout fires on a zero-length tick, app task gets a message
    directed_rows[10] = plain_row(OP_TICK, 0, 0, 0, 0);
    // event-less timer, stopped by its own key
    directed_rows[11] = plain_row(OP_START_ONESHOT, 16'h0007, 16'h0000, 100, 0);
    directed_rows[12] = plain_row(OP_STOP, 16'h0007, 16'h0000, 0, 0);
    // stopped timer only answers to event zero
    directed_rows[13] = plain_row(OP_START_RELOAD, 16'h0002, 16'h0003, 3, 0);
    directed_rows[14] = plain_row(OP_STOP, 16'h0002, 16'h0003, 0, 0);
    directed_rows[15] = plain_row(OP_QUERY, 16'h0002, 16'h0003, 0, 0);
    directed_rows[16] = plain_row(OP_QUERY, 16'h0002, 16'h0000, 0, 0);
    // restart keeps the reload period
    directed_rows[17] = plain_row(OP_START_RELOAD, 16'h0005, 16'h0005, 10, 0);
    directed_rows[18] = plain_row(OP_START_ONESHOT, 16'h0005, 16'h0005, 2, 0);
    directed_rows[19] = plain_row(OP_TICK, 0, 0, 0, 2);
    directed_rows[20] = plain_row(OP_TICK, 0, 0, 0, 3);
    directed_rows[21] = plain_row(OP_START_ONESHOT, 16'h0000, 16'h0001, 1, 0);
    // full-scale tick: saturation, several expiries, clock wrap
    directed_rows[22] = plain_row(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF);
    directed_rows[23] = plain_row(OP_QUERY, 16'h0005, 16'h0005, 0, 0);
  endtask

  // Key pools so that random stops and queries hit live timers
  task automatic refresh_pools();
    int i;
    task_pool[0]  = app_task;
    event_pool[0] = 16'(1 << $urandom_range(0, 15));
    for (i = 1; i < 4; i++) begin
      task_pool[i]  = 16'($urandom);
      event_pool[i] = 16'($urandom);
    end
  endtask

  function automatic in_word_t make_item(input int unsigned mix);
    in_word_t    w;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       w.task_id = 16'h0000;
      1:       w.task_id = 16'hFFFF;
      2:       w.task_id = 16'($urandom);
      default: w.task_id = task_pool[$urandom_range(0, 3)];
    endcase
    case ($urandom_range(0, 11))
      0:       w.evt_bits = 16'h0000;
      1:       w.evt_bits = 16'hFFFF;
      2:       w.evt_bits = 16'($urandom);
      default: w.evt_bits = event_pool[$urandom_range(0, 3)];
    endcase
    case ($urandom_range(0, 9))
      0:       w.timeout_ms = '0;
      1:       w.timeout_ms = 32'hFFFF_FFFF;
      2:       w.timeout_ms = $urandom;
      default: w.timeout_ms = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 19))
      0, 1:    w.elapsed_ms = '0;
      2, 3:    w.elapsed_ms = $urandom;
      4:       w.elapsed_ms = 32'hFFFF_FFFF;
      default: w.elapsed_ms = $urandom_range(0, 12);
    endcase
    case (mix)
      MIX_FILL: begin
        // fresh keys with long timeouts until the table runs out of slots
        if (roll < 75) begin
          w.op = $urandom_range(0, 1) ? OP_START_RELOAD : OP_START_ONESHOT;
          if (roll < 55) w.task_id = 16'($urandom);
          w.timeout_ms = $urandom_range(1000, 1_000_000);
        end else if (roll < 85) w.op = OP_QUERY;
        else if (roll < 95) begin
          w.op         = OP_TICK;
          w.elapsed_ms = $urandom_range(0, 3);
        end else w.op = OP_STOP;
      end
      MIX_TICKS: begin
        if (roll < 30)      w.op = $urandom_range(0, 1) ? OP_START_RELOAD : OP_START_ONESHOT;
        else if (roll < 40) w.op = OP_STOP;
        else if (roll < 50) w.op = OP_QUERY;
        else if (roll < 95) w.op = OP_TICK;
        else                w.op = 3'($urandom_range(5, 7));
      end
      default: begin
        if (roll < 40)      w.op = $urandom_range(0, 1) ? OP_START_RELOAD : OP_START_ONESHOT;
        else if (roll < 52) w.op = OP_STOP;
        else if (roll < 67) w.op = OP_QUERY;
        else if (roll < 92) w.op = OP_TICK;
        else                w.op = 3'($urandom_range(5, 7));
      end
    endcase
    return w;
  endfunction

  // Offer one word and hold it until taken; valid stays up for the caller
  task automatic offer_word(input in_word_t w, input bit typed, input out_word_t want);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    advance_table(w, !typed);
    if (typed) expected_words.push_back(want);
  endtask

  // Bursts of back-to-back words separated by random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    else begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 9);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Write the app task register, then read it back
  task automatic set_app_task(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APP_TASK_ADDR;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    app_task = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, value}) begin
      $display("%0t: app_task_id readback mismatch: expected %0h, got %0h",
               $time, {16'h0000, value}, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %0h", $time, out_data);
        errors++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_data.kind == KIND_EXPIRY) expiries_seen++;
        check_field("kind", want.kind, out_data.kind);
        check_field("status", want.status, out_data.status);
        check_field("fired_task", want.fired_task, out_data.fired_task);
        check_field("fired_event", want.fired_event, out_data.fired_event);
        check_field("as_message", want.as_message, out_data.as_message);
        check_field("remaining_ms", want.remaining_ms, out_data.remaining_ms);
        check_field("active_count", want.active_count, out_data.active_count);
        check_field("clock_ms", want.clock_ms, out_data.clock_ms);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // Result sink: stall patterns picked at random, plus one long hold-off
  initial begin : result_sink
    int unsigned cyc;
    int unsigned mode;
    cyc       = 0;
    mode      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= (cyc % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    logic [15:0] phase_app [N_PHASES];
    int unsigned phase_mix [N_PHASES];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    errors       = 0;
    words_sent   = 0;
    words_checked = 0;
    expiries_seen = 0;
    full_answers = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    app_task     = '0;
    sys_clock_ms = '0;
    for (k = 0; k < NT; k++) begin
      tmr_valid[k]  = 1'b0;
      tmr_task[k]   = '0;
      tmr_event[k]  = '0;
      tmr_left[k]   = '0;
      tmr_period[k] = '0;
    end
    phase_app[0] = 16'hFFFF;
    phase_app[1] = 16'($urandom);
    phase_app[2] = 16'h0000;
    phase_app[3] = 16'h8000;
    phase_mix[0] = MIX_MIXED;
    phase_mix[1] = MIX_FILL;
    phase_mix[2] = MIX_MIXED;
    phase_mix[3] = MIX_TICKS;
    load_directed();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (k = 0; k < N_DIRECTED; k++) begin
      offer_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].want);
      pace_sender();
    end
    drain();

    // random phases, each under its own app task setting
    for (ph = 0; ph < N_PHASES; ph++) begin
      set_app_task(phase_app[ph]);
      refresh_pools();
      // the table is full after the fill phase: hold the output while words queue up
      if (ph == 2) hold_off_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        offer_word(make_item(phase_mix[ph]), 1'b0, '0);
        pace_sender();
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d command words under %0d app task settings; checked %0d result words.",
             words_sent, N_PHASES + 1, words_checked);
    $display("Saw %0d expiries and %0d table-full answers; %0d mismatches.",
             expiries_seen, full_answers, errors);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
